>>> src/rme_pkg.sv
// Shared constants and the arctangent table for the rotation matrix to Euler angle block.
package rme_pkg;

  localparam int DEF_ELEMENT_BITS     = 16;
  localparam int DEF_ANGLE_ITERATIONS = 16;
  localparam int LIMIT_BITS           = 15;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(1);

  // angle accumulator, Q.20 radians
  localparam int ZW = 24;
  localparam logic signed [ZW-1:0] PI_Q20        = ZW'(3294199);
  localparam logic signed [ZW-1:0] ANGLE_PI      = ZW'(25736);
  localparam logic signed [ZW-1:0] ANGLE_HALF_PI = ZW'(12868);

  localparam int ROLL_W  = 16;
  localparam int PITCH_W = 15;
  localparam int YAW_W   = 16;

  // atan(2^-i) in Q.20, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_q20(input int i);
    logic signed [ZW-1:0] t;
    case (i)
      0:       t = ZW'(823550);
      1:       t = ZW'(486170);
      2:       t = ZW'(256879);
      3:       t = ZW'(130396);
      4:       t = ZW'(65451);
      5:       t = ZW'(32757);
      6:       t = ZW'(16383);
      7:       t = ZW'(8192);
      8:       t = ZW'(4096);
      9:       t = ZW'(2048);
      10:      t = ZW'(1024);
      11:      t = ZW'(512);
      12:      t = ZW'(256);
      13:      t = ZW'(128);
      14:      t = ZW'(64);
      15:      t = ZW'(32);
      16:      t = ZW'(16);
      17:      t = ZW'(8);
      18:      t = ZW'(4);
      19:      t = ZW'(2);
      20:      t = ZW'(1);
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

>>> src/rme_sqrt_cell.sv
// One bit-pair step of the integer square root chain.
module rme_sqrt_cell #(
  parameter int EB   = rme_pkg::DEF_ELEMENT_BITS,
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*EB-1:0] v_i,
  input  logic [2*EB-1:0] res_i,
  output logic [2*EB-1:0] v_o,
  output logic [2*EB-1:0] res_o
);

  localparam logic [2*EB-1:0] BIT = (2*EB)'(1) << (2*(EB-1-STEP));

  logic [2*EB-1:0] trial;
  logic [2*EB-1:0] v_r, res_r, v_nxt, res_nxt;

  assign trial = res_i + BIT;

  always_comb begin
    if (v_i >= trial) begin
      v_nxt   = v_i - trial;
      res_nxt = (res_i >> 1) + BIT;
    end else begin
      v_nxt   = v_i;
      res_nxt = res_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r   <= v_nxt;
      res_r <= res_nxt;
    end
  end

  assign v_o   = v_r;
  assign res_o = res_r;

endmodule

>>> src/rme_cordic_cell.sv
// One vectoring-mode CORDIC rotation step.
module rme_cordic_cell #(
  parameter int W    = rme_pkg::DEF_ELEMENT_BITS + 20,
  parameter int STEP = 0
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [W-1:0]          x_i,
  input  logic signed [W-1:0]          y_i,
  input  logic signed [rme_pkg::ZW-1:0] z_i,
  output logic signed [W-1:0]          x_o,
  output logic signed [W-1:0]          y_o,
  output logic signed [rme_pkg::ZW-1:0] z_o
);

  localparam logic signed [rme_pkg::ZW-1:0] TA = rme_pkg::atan_q20(STEP);

  logic signed [W-1:0] dx, dy, x_r, y_r, x_nxt, y_nxt;
  logic signed [rme_pkg::ZW-1:0] z_r, z_nxt;
  logic pos;

  assign dx  = y_i >>> STEP;
  assign dy  = x_i >>> STEP;
  assign pos = !y_i[W-1] && (y_i != '0);

  always_comb begin
    if (pos) begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + TA;
    end else begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - TA;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

>>> src/rotation_matrix_to_euler_angles.sv
// Top level: rotation matrix to roll, pitch and yaw, fully pipelined.
// Usage:
//   in_*   : one matrix item (r00 r01 r10 r11 r20 r21 r22) per handshake.
//   out_*  : one item with roll and yaw in Q3.13, pitch in Q2.13, and the gimbal flag.
//   cfg_*  : write of near_zero_limit; always ready, write only while idle.
// Throughput: one item per cycle while the output is not stalled. Stages:
// squares, sum, the square root chain (one cell per result bit), CORDIC
// prescale, the CORDIC chain (one cell per iteration) and the output register.
// The whole pipeline advances only while the output register is empty or
// being taken; when the receiver stalls, in_tready drops and every stage
// holds. Reset clears all valid bits and sets near_zero_limit to 1.
module rotation_matrix_to_euler_angles #(
  parameter int ELEMENT_BITS     = rme_pkg::DEF_ELEMENT_BITS,
  parameter int ANGLE_ITERATIONS = rme_pkg::DEF_ANGLE_ITERATIONS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // r00, r01, r10, r11, r20, r21, r22 (ELEMENT_BITS each), zero padded
  input  logic [((7*ELEMENT_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // roll_angle[15:0], pitch_angle[30:16], yaw_angle[46:31], zero pad
  output logic [47:0] out_tdata,
  // gimbal_lock
  output logic out_tuser,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [rme_pkg::LIMIT_BITS-1:0] cfg_data
);

  localparam int EB = ELEMENT_BITS;
  localparam int IT = ANGLE_ITERATIONS;
  localparam int W  = EB + 20;
  localparam int ZW = rme_pkg::ZW;
  localparam int EW = EB + 1;
  localparam int SW = 5*EW + 1;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  logic [rme_pkg::LIMIT_BITS-1:0] limit_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= rme_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      limit_r <= cfg_data;
    end
  end

  // input unpack
  logic signed [EB-1:0] r [7];
  for (genvar k = 0; k < 7; k++) begin : g_unpack
    assign r[k] = in_tdata[k*EB +: EB];
  end

  logic [EB-1:0] a00, a10;
  logic lock;
  logic [SW-1:0] side_nxt;
  logic signed [EW-1:0] ry, rx;
  assign a00  = r[0][EB-1] ? EB'(-r[0]) : EB'(r[0]);
  assign a10  = r[2][EB-1] ? EB'(-r[2]) : EB'(r[2]);
  assign lock = (32'(a00) < 32'(limit_r)) && (32'(a10) < 32'(limit_r));
  assign ry   = lock ? EW'(r[1]) : EW'(r[5]);
  assign rx   = lock ? EW'(r[3]) : EW'(r[6]);
  assign side_nxt = {lock, -EW'(r[4]), EW'(r[0]), EW'(r[2]), rx, ry};

  // squares, then sum
  logic [2*EB-1:0] sq00_r, sq10_r, sum_r;
  logic [SW-1:0] sideb_r, sidec_r;
  logic vb_r, vc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      vb_r <= in_tvalid;
      vc_r <= vb_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sq00_r  <= a00 * a00;
      sq10_r  <= a10 * a10;
      sideb_r <= side_nxt;
      sum_r   <= sq00_r + sq10_r;
      sidec_r <= sideb_r;
    end
  end

  // square root chain
  logic [2*EB-1:0] sv [EB+1];
  logic [2*EB-1:0] sres [EB+1];
  logic [SW-1:0] sqside_r [EB];
  logic sqval_r [EB];
  assign sv[0]   = sum_r;
  assign sres[0] = '0;
  for (genvar k = 0; k < EB; k++) begin : g_sqrt
    rme_sqrt_cell #(.EB(EB), .STEP(k)) u_cell (
      .clk(clk), .en(en),
      .v_i(sv[k]), .res_i(sres[k]),
      .v_o(sv[k+1]), .res_o(sres[k+1])
    );
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sqval_r[k] <= 1'b0;
      end else if (en) begin
        sqval_r[k] <= (k == 0) ? vc_r : sqval_r[k == 0 ? 0 : k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sqside_r[k] <= (k == 0) ? sidec_r : sqside_r[k == 0 ? 0 : k-1];
      end
    end
  end

  // lane 0 roll, lane 1 pitch, lane 2 yaw
  logic [SW-1:0] sd;
  logic signed [EW-1:0] ly [3];
  logic signed [EW-1:0] lx [3];
  assign sd    = sqside_r[EB-1];
  assign ly[0] = sd[0 +: EW];
  assign lx[0] = sd[EW +: EW];
  assign ly[2] = sd[2*EW +: EW];
  assign lx[2] = sd[3*EW +: EW];
  assign ly[1] = sd[4*EW +: EW];
  assign lx[1] = {1'b0, sres[EB][EB-1:0]};

  logic signed [W-1:0] cx [3][IT+1];
  logic signed [W-1:0] cy [3][IT+1];
  logic signed [ZW-1:0] cz [3][IT+1];
  logic [2:0] pzero_r;
  logic plock_r, pv_r;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic neg;
    logic signed [EW-1:0] xs, ys;
    logic signed [W-1:0] px_r, py_r;
    logic signed [ZW-1:0] pz_r, z0;
    assign neg = lx[l][EW-1];
    assign xs  = neg ? -lx[l] : lx[l];
    assign ys  = neg ? -ly[l] : ly[l];
    assign z0  = neg ? (ly[l][EW-1] ? -rme_pkg::PI_Q20 : rme_pkg::PI_Q20) : '0;
    always_ff @(posedge clk) begin
      if (en) begin
        px_r       <= W'(xs) <<< 16;
        py_r       <= W'(ys) <<< 16;
        pz_r       <= z0;
        pzero_r[l] <= (lx[l] == '0) && (ly[l] == '0);
      end
    end
    assign cx[l][0] = px_r;
    assign cy[l][0] = py_r;
    assign cz[l][0] = pz_r;
    for (genvar k = 0; k < IT; k++) begin : g_step
      rme_cordic_cell #(.W(W), .STEP(k)) u_cell (
        .clk(clk), .en(en),
        .x_i(cx[l][k]), .y_i(cy[l][k]), .z_i(cz[l][k]),
        .x_o(cx[l][k+1]), .y_o(cy[l][k+1]), .z_o(cz[l][k+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (en) begin
      pv_r <= sqval_r[EB-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      plock_r <= sd[5*EW];
    end
  end

  logic [2:0] czero_r [IT];
  logic clock_r [IT];
  logic cv_r [IT];
  for (genvar k = 0; k < IT; k++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[k] <= 1'b0;
      end else if (en) begin
        cv_r[k] <= (k == 0) ? pv_r : cv_r[k == 0 ? 0 : k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        czero_r[k] <= (k == 0) ? pzero_r : czero_r[k == 0 ? 0 : k-1];
        clock_r[k] <= (k == 0) ? plock_r : clock_r[k == 0 ? 0 : k-1];
      end
    end
  end

  // round to Q3.13 and clamp
  logic signed [ZW-1:0] ang [3];
  for (genvar l = 0; l < 3; l++) begin : g_round
    logic signed [ZW-1:0] zr, lim;
    assign zr  = (cz[l][IT] + ZW'(64)) >>> 7;
    assign lim = (l == 1) ? rme_pkg::ANGLE_HALF_PI : rme_pkg::ANGLE_PI;
    always_comb begin
      if (czero_r[IT-1][l]) begin
        ang[l] = '0;
      end else if (zr > lim) begin
        ang[l] = lim;
      end else if (zr < -lim) begin
        ang[l] = -lim;
      end else begin
        ang[l] = zr;
      end
    end
  end

  logic out_valid_r, lock_r;
  logic [rme_pkg::ROLL_W-1:0]  roll_r;
  logic [rme_pkg::PITCH_W-1:0] pitch_r;
  logic [rme_pkg::YAW_W-1:0]   yaw_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= cv_r[IT-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      roll_r  <= ang[0][rme_pkg::ROLL_W-1:0];
      pitch_r <= ang[1][rme_pkg::PITCH_W-1:0];
      yaw_r   <= clock_r[IT-1] ? '0 : ang[2][rme_pkg::YAW_W-1:0];
      lock_r  <= clock_r[IT-1];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, yaw_r, pitch_r, roll_r};
  assign out_tuser  = lock_r;

  a_lock_yaw : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[46:31] == '0)
    else $error("yaw not zero under gimbal lock");

  a_pitch_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[30:16]) <= 15'sd12868) &&
                   ($signed(out_tdata[30:16]) >= -15'sd12868))
    else $error("pitch out of range");

  a_stall : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");

endmodule

>>> verif/rotation_matrix_to_euler_angles_test.sv
// Stream testbench for the rotation matrix to Euler angle block with a built-in angle predictor.
module rotation_matrix_to_euler_angles_test;

  typedef struct packed {
    logic signed [15:0] r22, r21, r20, r11, r10, r01, r00;
  } matrix_t;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               lock;
  } angles_t;

  localparam int LATENCY = 36;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [111:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [47:0] out_tdata;
  logic out_tuser;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [rme_pkg::LIMIT_BITS-1:0] cfg_data = '0;

  rotation_matrix_to_euler_angles dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  matrix_t pending_mats[$];
  angles_t expected_angles[$];
  logic [rme_pkg::LIMIT_BITS-1:0] zero_limit = rme_pkg::LIMIT_RESET;
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint isqrt(longint v);
    longint r = 0;
    while ((r + 1) * (r + 1) <= v) r = r + 1;
    return r;
  endfunction

  function automatic longint cordic_atan2(longint y, longint x, longint lim);
    longint z = 0;
    longint dx, dy;
    longint tbl[21] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y < 0) ? -3294199 : 3294199;
      x = -x;
      y = -y;
    end
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < rme_pkg::DEF_ANGLE_ITERATIONS; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y > 0) begin
        x = x + dx; y = y - dy; z = z + tbl[i];
      end else begin
        x = x - dx; y = y + dy; z = z - tbl[i];
      end
    end
    z = shr_floor(z + 64, 7);
    if (z > lim) z = lim;
    if (z < -lim) z = -lim;
    return z;
  endfunction

  function automatic angles_t euler_of(matrix_t m);
    angles_t a;
    longint a00, a10, hyp;
    a00 = (m.r00 < 0) ? -longint'(m.r00) : longint'(m.r00);
    a10 = (m.r10 < 0) ? -longint'(m.r10) : longint'(m.r10);
    hyp = isqrt(a00 * a00 + a10 * a10);
    a.lock = (a00 < zero_limit) && (a10 < zero_limit);
    a.pitch = 15'(cordic_atan2(-longint'(m.r20), hyp, 12868));
    if (a.lock) begin
      a.yaw = 0;
      a.roll = 16'(cordic_atan2(m.r01, m.r11, 25736));
    end else begin
      a.roll = 16'(cordic_atan2(m.r21, m.r22, 25736));
      a.yaw = 16'(cordic_atan2(m.r10, m.r00, 25736));
    end
    return a;
  endfunction

  // driver
  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      expected_angles.push_back(euler_of(matrix_t'(in_tdata)));
      void'(pending_mats.pop_front());
    end
    if (pending_mats.size() > 0 || (in_tvalid && !in_tready)) begin
      if (in_tvalid && !in_tready) begin
      end else if ($urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1;
        in_tdata <= pending_mats[0];
      end else
        in_tvalid <= 0;
    end else if (!(in_tvalid && !in_tready))
      in_tvalid <= 0;
  end

  // monitor
  always @(posedge clk) begin
    angles_t e;
    if (out_tvalid && out_tready) begin
      if (expected_angles.size() == 0) begin
        $error("unexpected item %h", out_tdata);
        errors++;
      end else begin
        e = expected_angles.pop_front();
        if (out_tdata[15:0] !== e.roll) begin
          $error("roll_angle exp %0d got %0d", e.roll, $signed(out_tdata[15:0])); errors++;
        end
        if (out_tdata[30:16] !== e.pitch) begin
          $error("pitch_angle exp %0d got %0d", e.pitch, $signed(out_tdata[30:16])); errors++;
        end
        if (out_tdata[46:31] !== e.yaw) begin
          $error("yaw_angle exp %0d got %0d", e.yaw, $signed(out_tdata[46:31])); errors++;
        end
        if (out_tuser !== e.lock) begin
          $error("gimbal_lock exp %0b got %0b", e.lock, out_tuser); errors++;
        end
      end
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 0;
    end else
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic wait_drained();
    while (pending_mats.size() != 0 || in_tvalid || expected_angles.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_limit(logic [rme_pkg::LIMIT_BITS-1:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    zero_limit = v;
  endtask

  function automatic logic signed [15:0] rand_elem(int mode, int lim);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(2 * lim)) - lim);
      default: return 16'($urandom_range(1) ? 16'sh7fff : 16'sh8000);
    endcase
  endfunction

  function automatic matrix_t rand_matrix(int lim);
    matrix_t m;
    bit near = ($urandom_range(3) == 0);
    m = matrix_t'(112'({$urandom, $urandom, $urandom, $urandom}));
    if ($urandom_range(7) == 0) m.r20 = rand_elem(2, 0);
    if (near) begin
      m.r00 = rand_elem(1, lim + 1);
      m.r10 = rand_elem(1, lim + 1);
    end
    if ($urandom_range(9) == 0) begin
      m.r21 = 0; m.r22 = 0;
    end
    if ($urandom_range(9) == 0) begin
      m.r01 = 0; m.r11 = 0;
    end
    return m;
  endfunction

  initial begin
    matrix_t m;
    logic [rme_pkg::LIMIT_BITS-1:0] limits[5] = '{15'd1, 15'd0, 15'd32767, 15'd300, 15'd4};
    logic signed [15:0] ext[4] = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1};
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: extremes, zero operands, gimbal lock at the reset limit
    for (int i = 0; i < 16; i++) begin
      m = '{ext[i % 4], ext[(i / 4) % 4], ext[(i + 1) % 4], ext[(i + 2) % 4],
            ext[(i / 4) % 4], ext[(i + 3) % 4], ext[i % 4]};
      pending_mats.push_back(m);
    end
    m = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    pending_mats.push_back(m);
    m = '{16'sd32767, 16'sd0, 16'sh8000, 16'sd32767, 16'sd0, 16'sd5, 16'sd0};
    pending_mats.push_back(m);
    m = '{16'sd0, -16'sd3, 16'sd32767, -16'sd4, 16'sd0, 16'sd0, 16'sd0};
    pending_mats.push_back(m);
    m = '{16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    pending_mats.push_back(m);
    wait_drained();
    for (int ph = 0; ph < 5; ph++) begin
      write_limit(limits[ph]);
      send_idle_pct = (ph < 2) ? 21 : (ph < 4) ? 55 : 0;
      recv_idle_pct = (ph < 2) ? 55 : (ph < 4) ? 21 : 0;
      for (int k = 0; k < 380; k++)
        pending_mats.push_back(rand_matrix(limits[ph]));
      if (ph == 4) begin
        hold_off = 200;
      end
      wait_drained();
    end
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule

>>> filelist.f
src/rme_pkg.sv
src/rme_sqrt_cell.sv
src/rme_cordic_cell.sv
src/rotation_matrix_to_euler_angles.sv
verif/rotation_matrix_to_euler_angles_test.sv
